/* hw/rtl/fds_pkg.sv */
package fds_pkg;

	localparam int NumFlows = 16;
	localparam int SlotW = $clog2(NumFlows);
	localparam int HeaderBytes = 56;
	localparam int MaxPayloadBytes = 2048;
	localparam int MaxLen = HeaderBytes + MaxPayloadBytes;
	localparam logic [33:0] BitsPerSecScale = 34'd8000000000;
	localparam logic [31:0] DelayMinReset = 32'd2147483647;
	// 1000 * 2^32 ns: first delay that saturates
	localparam logic [62:0] DelaySatNs = 63'd4294967296000;
	// ceil(2^34 / 125)
	localparam logic [27:0] Recip125 = 28'd137438954;

	localparam logic [1:0] CfgFlowWindow = 2'd0;
	localparam logic [1:0] CfgReportInterval = 2'd1;
	localparam logic [1:0] CfgForwardFlow = 2'd2;

	localparam logic [1:0] RecPacket = 2'd0;
	localparam logic [1:0] RecSummary = 2'd1;
	localparam logic [1:0] RecFlow = 2'd2;

	typedef struct packed {
		logic [31:0] flow_id;
		logic [62:0] send_time_ns;
		logic [62:0] arrive_time_ns;
		logic [11:0] length_bytes;
	} fds_in_t;

	typedef struct packed {
		logic [1:0]  record_type;
		logic [31:0] flow_key;
		logic [31:0] packet_count;
		logic [31:0] byte_count;
		logic [31:0] delay_sum;
		logic [31:0] delay_max;
		logic [31:0] delay_min;
		logic [31:0] mean_delay;
		logic [31:0] avg_speed_bps;
		logic        forward;
		logic        table_full;
		logic        last;
	} fds_out_t;

	typedef enum logic [0:0] {
		OP_DIV,
		OP_MUL
	} alu_op_t;

	typedef struct packed {
		logic        start;
		alu_op_t     op;
		logic [127:0] a;
		logic [63:0] b;
		logic [7:0]  nbits;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
		logic        over;
		logic [127:0] prod;
	} alu_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DLY_GO,
		S_DLY_WAIT,
		S_UPD,
		S_EMIT,
		S_AVG_GO,
		S_AVG_WAIT,
		S_MUL_GO,
		S_MUL_WAIT,
		S_SPD_GO,
		S_SPD_WAIT,
		S_SUM,
		S_WALK
	} fds_state_t;

endpackage

/* hw/rtl/fds_alu.sv */
module fds_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  fds_pkg::alu_req_t  req,
	output fds_pkg::alu_rsp_t  rsp
);
	import fds_pkg::*;

	logic         busy_q;
	alu_op_t      op_q;
	logic [127:0] a_q;
	logic [63:0]  b_q;
	logic [63:0]  r_q;
	logic [31:0]  q_q;
	logic         over_q;
	logic [7:0]   cnt_q;
	logic [33:0]  mplr_q;
	logic [127:0] acc_q;
	logic         done_q;

	logic [63:0]  r_sh;
	logic         ge;
	logic [63:0]  r_nx;

	always_comb begin
		r_sh = {r_q[62:0], a_q[127]};
		ge   = r_q[63] | (r_sh >= b_q);
		r_nx = ge ? (r_sh - b_q) : r_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 8'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q   <= req.op;
			a_q    <= req.a;
			b_q    <= req.b;
			r_q    <= '0;
			q_q    <= '0;
			over_q <= 1'b0;
			acc_q  <= '0;
			mplr_q <= BitsPerSecScale;
			cnt_q  <= (req.op == OP_MUL) ? 8'd34 : req.nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 8'd1;
			if (op_q == OP_MUL) begin
				if (mplr_q[0])
					acc_q <= acc_q + a_q;
				a_q    <= {a_q[126:0], 1'b0};
				mplr_q <= {1'b0, mplr_q[33:1]};
			end else begin
				r_q <= r_nx;
				q_q <= {q_q[30:0], ge};
				a_q <= {a_q[126:0], 1'b0};
				if (ge && cnt_q > 8'd32)
					over_q <= 1'b1;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = q_q;
	assign rsp.over = over_q;
	assign rsp.prod = acc_q;

endmodule

/* hw/rtl/flow_delay_statistics.sv */
// Path: an accepted input passes S_DLY_GO, S_DLY_WAIT and S_UPD to the packet word
// (no S_DLY_WAIT when arrival precedes send or the delay saturates); the divide by 1000
// is a two-step reciprocal multiply. Throughput: one packet at a time; in_ready is high
// only when idle, so a packet waits for its word and any report. A report runs 32-, 34-
// and 128-step passes of the shared divide/multiply unit, then one word per valid slot.
// Reset: asynchronous, active low; clears flow valid bits, window totals and control registers.
module flow_delay_statistics (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fds_pkg::fds_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output fds_pkg::fds_out_t out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_addr,
	input  logic [31:0]       cfg_wdata
);
	import fds_pkg::*;

	fds_state_t state_q, state_d;
	fds_state_t ret_q;
	alu_req_t   req;
	alu_rsp_t   rsp;

	logic [31:0] flow_window_q, report_interval_q, forward_id_q;

	logic [NumFlows-1:0] ent_valid_q;
	logic [31:0] ent_key_q   [NumFlows];
	logic [31:0] ent_pkts_q  [NumFlows];
	logic [31:0] ent_bytes_q [NumFlows];
	logic [31:0] ent_sum_q   [NumFlows];
	logic [31:0] ent_max_q   [NumFlows];
	logic [31:0] ent_min_q   [NumFlows];
	logic [63:0] ent_start_q [NumFlows];

	logic [31:0] win_pkts_q, win_sum_q, win_max_q, win_min_q;
	logic [63:0] win_bytes_q, win_start_q;

	fds_in_t     in_q;
	logic [11:0] len_q, pay_q;
	logic        fwd_q;
	logic [31:0] delay_q, avg_q, spd_q;
	logic [62:0] elapsed_q;
	logic        report_q;
	logic [127:0] prod_q;
	logic [SlotW-1:0] idx_q;
	fds_out_t    out_q;
	logic        out_valid_q;
	logic [62:0] diff_q;
	logic        early_q;
	logic [11:0] dq_hi_q;
	logic [6:0]  dq_rem_q;

	logic [11:0] len_c;
	logic        hit;
	logic        has_free;
	logic [SlotW-1:0] hit_slot, free_slot;
	logic [63:0] age;
	logic [63:0] elapsed_c;
	logic        above;
	logic        any_valid;
	logic [26:0] dk_num;
	logic [53:0] dk_prod;
	logic [19:0] dk_quo;
	logic [6:0]  dk_rem;

	fds_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_comb begin
		len_c = (in_data.length_bytes > 12'(MaxLen)) ? 12'(MaxLen) : in_data.length_bytes;
		hit = 1'b0;
		has_free = 1'b0;
		hit_slot = '0;
		free_slot = '0;
		for (int i = NumFlows - 1; i >= 0; i--) begin
			if (ent_valid_q[i] && ent_key_q[i] == in_q.flow_id) begin
				hit = 1'b1;
				hit_slot = SlotW'(i);
			end else if (!ent_valid_q[i]) begin
				has_free = 1'b1;
				free_slot = SlotW'(i);
			end
		end
		age = ({1'b0, in_q.arrive_time_ns} >= ent_start_q[hit_slot]) ?
			({1'b0, in_q.arrive_time_ns} - ent_start_q[hit_slot]) : 64'd0;
		elapsed_c = ({1'b0, in_q.arrive_time_ns} >= win_start_q) ?
			({1'b0, in_q.arrive_time_ns} - win_start_q) : 64'd0;
		above = 1'b0;
		for (int i = 0; i < NumFlows; i++)
			if (i > int'(idx_q) && ent_valid_q[i])
				above = 1'b1;
		any_valid = |ent_valid_q;
		// x/1000 = (x>>3)/125, long division by 125 in a 19-bit and a 20-bit digit
		dk_num = (state_q == S_DLY_WAIT) ? {dq_rem_q, diff_q[22:3]} : {8'd0, diff_q[41:23]};
		dk_prod = dk_num * Recip125;
		dk_quo = dk_prod[53:34];
		dk_rem = dk_num[6:0] - 7'(dk_quo[6:0] * 7'd125);
	end

	always_comb begin
		state_d   = state_q;
		req       = '0;
		req.op    = OP_DIV;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_DLY_GO;
			end
			S_DLY_GO: begin
				if (early_q || diff_q >= DelaySatNs)
					state_d = S_UPD;
				else
					state_d = S_DLY_WAIT;
			end
			S_DLY_WAIT: state_d = S_UPD;
			S_UPD: state_d = S_EMIT;
			S_EMIT: begin
				if (out_ready)
					state_d = ret_q;
			end
			S_AVG_GO: begin
				if (win_pkts_q != 32'd0) begin
					req.start = 1'b1;
					req.a = {win_sum_q, 96'd0};
					req.b = {32'd0, win_pkts_q};
					req.nbits = 8'd32;
					state_d = S_AVG_WAIT;
				end else begin
					state_d = S_MUL_GO;
				end
			end
			S_AVG_WAIT: begin
				if (rsp.done)
					state_d = S_MUL_GO;
			end
			S_MUL_GO: begin
				if (elapsed_q != 63'd0) begin
					req.start = 1'b1;
					req.op = OP_MUL;
					req.a = {64'd0, win_bytes_q};
					state_d = S_MUL_WAIT;
				end else begin
					state_d = S_SUM;
				end
			end
			S_MUL_WAIT: begin
				if (rsp.done)
					state_d = S_SPD_GO;
			end
			S_SPD_GO: begin
				req.start = 1'b1;
				req.a = prod_q;
				req.b = {1'b0, elapsed_q};
				req.nbits = 8'd128;
				state_d = S_SPD_WAIT;
			end
			S_SPD_WAIT: begin
				if (rsp.done)
					state_d = S_SUM;
			end
			S_SUM: state_d = S_EMIT;
			S_WALK: begin
				if (ent_valid_q[idx_q])
					state_d = S_EMIT;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_window_q     <= 32'd1000000000;
			report_interval_q <= 32'd2000000000;
			forward_id_q      <= 32'd23023;
			ent_valid_q       <= '0;
			win_pkts_q        <= '0;
			win_sum_q         <= '0;
			win_max_q         <= '0;
			win_min_q         <= DelayMinReset;
			win_bytes_q       <= '0;
			win_start_q       <= '0;
			out_valid_q       <= 1'b0;
			ret_q             <= S_IDLE;
			idx_q             <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CfgFlowWindow:     flow_window_q <= cfg_wdata;
					CfgReportInterval: report_interval_q <= cfg_wdata;
					CfgForwardFlow:    forward_id_q <= cfg_wdata;
					default: ;
				endcase
			end
			case (state_q)
				S_UPD: begin
					win_bytes_q <= win_bytes_q + 64'(pay_q);
					win_sum_q   <= win_sum_q + delay_q;
					if (delay_q > win_max_q)
						win_max_q <= delay_q;
					if (delay_q < win_min_q)
						win_min_q <= delay_q;
					win_pkts_q  <= win_pkts_q + 32'd1;
					if (!(hit && age < {32'd0, flow_window_q}) && (hit || has_free))
						ent_valid_q[hit ? hit_slot : free_slot] <= 1'b1;
					out_valid_q <= 1'b1;
					ret_q <= (elapsed_c >= {32'd0, report_interval_q}) ? S_AVG_GO : S_IDLE;
				end
				S_EMIT: begin
					if (out_ready)
						out_valid_q <= 1'b0;
				end
				S_SUM: begin
					out_valid_q <= 1'b1;
					ret_q <= any_valid ? S_WALK : S_IDLE;
					idx_q <= '0;
					win_pkts_q  <= '0;
					win_sum_q   <= '0;
					win_max_q   <= '0;
					win_min_q   <= DelayMinReset;
					win_bytes_q <= '0;
					win_start_q <= {1'b0, in_q.arrive_time_ns};
				end
				S_WALK: begin
					idx_q <= idx_q + SlotW'(1);
					if (ent_valid_q[idx_q]) begin
						out_valid_q <= 1'b1;
						ret_q <= above ? S_WALK : S_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				in_q    <= in_data;
				len_q   <= len_c;
				pay_q   <= (len_c > 12'(HeaderBytes)) ? len_c - 12'(HeaderBytes) : 12'd0;
				fwd_q   <= (in_data.flow_id == forward_id_q);
				diff_q  <= in_data.arrive_time_ns - in_data.send_time_ns;
				early_q <= (in_data.arrive_time_ns < in_data.send_time_ns);
				delay_q <= '0;
				avg_q   <= '0;
				spd_q   <= '0;
			end
			S_DLY_GO: begin
				dq_hi_q  <= dk_quo[11:0];
				dq_rem_q <= dk_rem;
				if (!early_q && diff_q >= DelaySatNs)
					delay_q <= 32'hFFFF_FFFF;
			end
			S_DLY_WAIT: begin
				delay_q <= {dq_hi_q, dk_quo};
			end
			S_UPD: begin
				elapsed_q <= elapsed_c[62:0];
				out_q <= '0;
				out_q.record_type <= RecPacket;
				out_q.flow_key <= in_q.flow_id;
				out_q.forward <= fwd_q;
				out_q.last <= !(elapsed_c >= {32'd0, report_interval_q});
				if (hit && age < {32'd0, flow_window_q}) begin
					ent_pkts_q[hit_slot]  <= ent_pkts_q[hit_slot] + 32'd1;
					ent_sum_q[hit_slot]   <= ent_sum_q[hit_slot] + delay_q;
					ent_bytes_q[hit_slot] <= ent_bytes_q[hit_slot] + 32'(len_q);
					if (delay_q > ent_max_q[hit_slot])
						ent_max_q[hit_slot] <= delay_q;
					if (delay_q < ent_min_q[hit_slot])
						ent_min_q[hit_slot] <= delay_q;
					out_q.packet_count <= ent_pkts_q[hit_slot] + 32'd1;
					out_q.byte_count   <= ent_bytes_q[hit_slot] + 32'(len_q);
					out_q.delay_sum    <= ent_sum_q[hit_slot] + delay_q;
					out_q.delay_max    <= (delay_q > ent_max_q[hit_slot]) ?
						delay_q : ent_max_q[hit_slot];
					out_q.delay_min    <= (delay_q < ent_min_q[hit_slot]) ?
						delay_q : ent_min_q[hit_slot];
				end else if (hit || has_free) begin
					ent_key_q[hit ? hit_slot : free_slot]   <= in_q.flow_id;
					ent_pkts_q[hit ? hit_slot : free_slot]  <= 32'd1;
					ent_bytes_q[hit ? hit_slot : free_slot] <= 32'(len_q);
					ent_sum_q[hit ? hit_slot : free_slot]   <= delay_q;
					ent_max_q[hit ? hit_slot : free_slot]   <= delay_q;
					ent_min_q[hit ? hit_slot : free_slot]   <= delay_q;
					ent_start_q[hit ? hit_slot : free_slot] <= {1'b0, in_q.arrive_time_ns};
					out_q.packet_count <= 32'd1;
					out_q.byte_count   <= 32'(len_q);
					out_q.delay_sum    <= delay_q;
					out_q.delay_max    <= delay_q;
					out_q.delay_min    <= delay_q;
				end else begin
					out_q.table_full <= 1'b1;
				end
			end
			S_AVG_WAIT: begin
				if (rsp.done)
					avg_q <= rsp.quot;
			end
			S_MUL_WAIT: begin
				if (rsp.done)
					prod_q <= rsp.prod;
			end
			S_SPD_WAIT: begin
				if (rsp.done)
					spd_q <= rsp.over ? 32'hFFFF_FFFF : rsp.quot;
			end
			S_SUM: begin
				out_q <= '0;
				out_q.record_type   <= RecSummary;
				out_q.packet_count  <= win_pkts_q;
				out_q.byte_count    <= win_bytes_q[31:0];
				out_q.delay_sum     <= win_sum_q;
				out_q.delay_max     <= win_max_q;
				out_q.delay_min     <= win_min_q;
				out_q.mean_delay    <= avg_q;
				out_q.avg_speed_bps <= spd_q;
				out_q.last          <= !any_valid;
			end
			S_WALK: begin
				out_q <= '0;
				out_q.record_type  <= RecFlow;
				out_q.flow_key     <= ent_key_q[idx_q];
				out_q.packet_count <= ent_pkts_q[idx_q];
				out_q.byte_count   <= ent_bytes_q[idx_q];
				out_q.delay_sum    <= ent_sum_q[idx_q];
				out_q.delay_max    <= ent_max_q[idx_q];
				out_q.delay_min    <= ent_min_q[idx_q];
				out_q.last         <= !above;
			end
			default: ;
		endcase
	end

endmodule

/* hw/rtl/fds_checker.sv */
module fds_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input fds_pkg::fds_out_t out_data
);
	import fds_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready))
		else $error("ready for input while a word is pending");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled word changed");

	a_summary_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.record_type != RecPacket |->
		!out_data.forward && !out_data.table_full)
		else $error("flag set outside packet word");

endmodule

bind flow_delay_statistics fds_checker u_fds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

/* tb/tb_flow_delay_statistics.sv */
module tb_flow_delay_statistics;
	timeunit 1ns;
	timeprecision 1ps;

	import fds_pkg::*;

	localparam logic [1:0] CfgSpare = 2'd3;
	localparam int CycleLimit = 2000000;
	localparam int RandItems = 420;
	localparam logic [63:0] Mask63 = 64'h7FFF_FFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	fds_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	fds_out_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_addr = '0;
	logic [31:0] cfg_wdata = '0;

	flow_delay_statistics i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// flow table and window totals as the block should hold them
	logic        flow_used [NumFlows];
	logic [31:0] flow_key_q [NumFlows];
	logic [31:0] flow_pkts [NumFlows];
	logic [31:0] flow_bytes [NumFlows];
	logic [31:0] flow_dsum [NumFlows];
	logic [31:0] flow_dmax [NumFlows];
	logic [31:0] flow_dmin [NumFlows];
	logic [63:0] flow_start [NumFlows];
	logic [31:0] win_pkts = '0;
	logic [31:0] win_dsum = '0;
	logic [31:0] win_dmax = '0;
	logic [31:0] win_dmin = DelayMinReset;
	logic [63:0] win_bytes = '0;
	logic [63:0] win_start = '0;
	logic [31:0] window_ns = 32'd1000000000;
	logic [31:0] interval_ns = 32'd2000000000;
	logic [31:0] forward_id = 32'd23023;

	fds_out_t expected_records[$];
	int errors = 0;
	int words_taken = 0;
	int items_sent = 0;
	int cycles = 0;

	initial begin
		for (int i = 0; i < NumFlows; i++) begin
			flow_used[i] = 1'b0;
		end
	end

	function automatic void account_packet(fds_in_t p);
		logic [31:0] len, pay, dly, spd;
		logic [63:0] arr, snd, dq, age, elapsed;
		logic [127:0] quo;
		int slot, freeslot;
		fds_out_t r;
		slot = -1;
		freeslot = -1;
		arr = {1'b0, p.arrive_time_ns};
		snd = {1'b0, p.send_time_ns};
		len = (p.length_bytes > MaxLen) ? MaxLen : {20'b0, p.length_bytes};
		pay = (len > HeaderBytes) ? len - HeaderBytes : '0;
		dly = '0;
		if (arr >= snd) begin
			dq = (arr - snd) / 64'd1000;
			dly = (dq > 64'hFFFF_FFFF) ? '1 : dq[31:0];
		end
		win_bytes += {32'b0, pay};
		win_dsum += dly;
		if (dly > win_dmax) win_dmax = dly;
		if (dly < win_dmin) win_dmin = dly;
		win_pkts++;
		for (int i = 0; i < NumFlows; i++) begin
			if (flow_used[i] && flow_key_q[i] == p.flow_id) begin
				if (slot < 0) slot = i;
			end else if (!flow_used[i] && freeslot < 0) begin
				freeslot = i;
			end
		end
		if (slot >= 0) begin
			age = (arr >= flow_start[slot]) ? arr - flow_start[slot] : '0;
			if (age < {32'b0, window_ns}) begin
				flow_pkts[slot]++;
				flow_dsum[slot] += dly;
				if (dly > flow_dmax[slot]) flow_dmax[slot] = dly;
				if (dly < flow_dmin[slot]) flow_dmin[slot] = dly;
				flow_bytes[slot] += len;
			end else begin
				freeslot = slot;
				slot = -1;
			end
		end
		if (slot < 0 && freeslot >= 0) begin
			slot = freeslot;
			flow_used[slot] = 1'b1;
			flow_key_q[slot] = p.flow_id;
			flow_pkts[slot] = 32'd1;
			flow_bytes[slot] = len;
			flow_dsum[slot] = dly;
			flow_dmax[slot] = dly;
			flow_dmin[slot] = dly;
			flow_start[slot] = arr;
		end
		r = '0;
		r.record_type = RecPacket;
		r.flow_key = p.flow_id;
		r.forward = (p.flow_id == forward_id);
		if (slot >= 0) begin
			r.packet_count = flow_pkts[slot];
			r.byte_count = flow_bytes[slot];
			r.delay_sum = flow_dsum[slot];
			r.delay_max = flow_dmax[slot];
			r.delay_min = flow_dmin[slot];
		end else begin
			r.table_full = 1'b1;
		end
		expected_records.push_back(r);
		elapsed = (arr >= win_start) ? arr - win_start : '0;
		if (elapsed >= {32'b0, interval_ns}) begin
			spd = '0;
			if (elapsed != 0) begin
				quo = ({64'b0, win_bytes} * 128'd8000000000) / {64'b0, elapsed};
				spd = (quo > 128'hFFFF_FFFF) ? '1 : quo[31:0];
			end
			r = '0;
			r.record_type = RecSummary;
			r.packet_count = win_pkts;
			r.byte_count = win_bytes[31:0];
			r.delay_sum = win_dsum;
			r.delay_max = win_dmax;
			r.delay_min = win_dmin;
			r.mean_delay = (win_pkts != 0) ? win_dsum / win_pkts : '0;
			r.avg_speed_bps = spd;
			expected_records.push_back(r);
			for (int i = 0; i < NumFlows; i++) begin
				if (flow_used[i]) begin
					r = '0;
					r.record_type = RecFlow;
					r.flow_key = flow_key_q[i];
					r.packet_count = flow_pkts[i];
					r.byte_count = flow_bytes[i];
					r.delay_sum = flow_dsum[i];
					r.delay_max = flow_dmax[i];
					r.delay_min = flow_dmin[i];
					expected_records.push_back(r);
				end
			end
			win_pkts = '0;
			win_bytes = '0;
			win_dsum = '0;
			win_dmax = '0;
			win_dmin = DelayMinReset;
			win_start = arr;
		end
		expected_records[expected_records.size() - 1].last = 1'b1;
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h expected %h (word %0d)", what, got, want, words_taken);
		errors++;
	endtask

	task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want) flag_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin
		fds_out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_records.size() == 0) begin
				flag_mismatch("unexpected word", out_data.flow_key, '0);
			end else begin
				e = expected_records.pop_front();
				check_field("record_type", out_data.record_type, e.record_type);
				check_field("flow_key", out_data.flow_key, e.flow_key);
				check_field("packet_count", out_data.packet_count, e.packet_count);
				check_field("byte_count", out_data.byte_count, e.byte_count);
				check_field("delay_sum", out_data.delay_sum, e.delay_sum);
				check_field("delay_max", out_data.delay_max, e.delay_max);
				check_field("delay_min", out_data.delay_min, e.delay_min);
				check_field("mean_delay", out_data.mean_delay, e.mean_delay);
				check_field("avg_speed_bps", out_data.avg_speed_bps, e.avg_speed_bps);
				check_field("forward", out_data.forward, e.forward);
				check_field("table_full", out_data.table_full, e.table_full);
				check_field("last", out_data.last, e.last);
			end
			words_taken++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off, a quiet stretch
	initial begin
		bit held;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && words_taken >= 40) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (600) @(negedge clk);
			end
			if (words_taken >= 300 && words_taken < 700) out_ready <= 1'b1;
			else out_ready <= ($urandom_range(0, 99) >= 21);
		end
	end

	task automatic offer_packet(fds_in_t p, bit typed, logic [31:0] t_count,
			logic [31:0] t_dmax, logic t_full);
		int idx;
		@(negedge clk);
		if (!(items_sent >= 150 && items_sent < 260) && $urandom_range(0, 99) < 21) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		do @(posedge clk); while (!in_ready);
		idx = expected_records.size();
		account_packet(p);
		if (typed) begin
			expected_records[idx].packet_count = t_count;
			expected_records[idx].delay_max = t_dmax;
			expected_records[idx].table_full = t_full;
		end
		items_sent++;
	endtask

	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_records.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			CfgFlowWindow: window_ns = val;
			CfgReportInterval: interval_ns = val;
			CfgForwardFlow: forward_id = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	typedef struct {
		fds_in_t     word;
		bit          typed;
		logic [31:0] count;
		logic [31:0] dmax;
		logic        full;
	} row_t;

	row_t rows[$];
	logic [31:0] flow_pool [24];

	initial begin
		row_t rw;
		logic [63:0] now, arr, snd;
		fds_in_t p;
		int r;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		rw = '{'{32'd23023, 63'd0, 63'd5000, 12'd100}, 1'b1, 32'd1, 32'd5, 1'b0};
		rows.push_back(rw);
		// arrival before send
		rw = '{'{32'd0, 63'd1000, 63'd0, 12'd0}, 1'b1, 32'd1, 32'd0, 1'b0};
		rows.push_back(rw);
		for (int i = 1; i <= 14; i++) begin
			rw.word = '{i, 63'(i * 1000), 63'(i * 1000 + 7000),
				(i == 3) ? 12'hFFF : 12'(56 + i)};
			rw.typed = 1'b0;
			rows.push_back(rw);
		end
		// table is full now
		rw = '{'{32'hFFFF_FFFF, 63'd0, 63'd8000, 12'd2104}, 1'b1, 32'd0, 32'd0, 1'b1};
		rows.push_back(rw);
		rw = '{'{32'd23023, 63'd0, 63'd9000, 12'd55}, 1'b0, 32'd0, 32'd0, 1'b0};
		rows.push_back(rw);
		rw.word = '{32'd1, Mask63[62:0], 63'd10000, 12'd56};
		rows.push_back(rw);
		// saturated delay, aged entry, first report
		rw.word = '{32'd0, 63'd0, 63'(64'd1 << 53), 12'd2104};
		rows.push_back(rw);
		rw.word = '{32'd5, 63'((64'd1 << 53) + 5), 63'((64'd1 << 53) + 10), 12'd57};
		rows.push_back(rw);
		foreach (rows[i]) offer_packet(rows[i].word, rows[i].typed, rows[i].count,
			rows[i].dmax, rows[i].full);

		flow_pool[0] = 32'd0;
		flow_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 24; i++) flow_pool[i] = $urandom;
		now = (64'd1 << 53) + 64'd20;

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				0: begin
					write_reg(CfgFlowWindow, 32'd1);
					write_reg(CfgReportInterval, 32'd1);
					write_reg(CfgForwardFlow, flow_pool[0]);
					write_reg(CfgSpare, $urandom);
				end
				1: begin
					write_reg(CfgFlowWindow, 32'hFFFF_FFFF);
					write_reg(CfgReportInterval, 32'hFFFF_FFFF);
					write_reg(CfgForwardFlow, 32'hFFFF_FFFF);
				end
				2: begin
					write_reg(CfgFlowWindow, 32'd50000);
					write_reg(CfgReportInterval, 32'd300000);
					write_reg(CfgForwardFlow, flow_pool[$urandom_range(2, 23)]);
				end
				default: begin
					write_reg(CfgFlowWindow, $urandom_range(1000, 20000000));
					write_reg(CfgReportInterval, $urandom_range(10000, 80000000));
					write_reg(CfgForwardFlow, flow_pool[$urandom_range(0, 23)]);
				end
			endcase
			for (int k = 0; k < RandItems / 4; k++) begin
				r = $urandom_range(0, 99);
				if (r < 80) now += 64'($urandom_range(0, 20000));
				else if (r < 95) now += 64'($urandom_range(0, 3000000));
				else now += 64'($urandom) + 64'h1_0000_0000;
				arr = now;
				if ($urandom_range(0, 99) < 8) arr = now - 64'($urandom_range(0, 50000));
				r = $urandom_range(0, 99);
				if (r < 85) snd = arr - 64'($urandom_range(0, 2000000));
				else if (r < 93) snd = arr + 64'($urandom_range(1, 5000));
				else snd = {$urandom, $urandom} & Mask63;
				p.flow_id = ($urandom_range(0, 99) < 5) ? $urandom
					: flow_pool[$urandom_range(0, 23)];
				p.send_time_ns = snd[62:0];
				p.arrive_time_ns = arr[62:0];
				r = $urandom_range(0, 99);
				if (r < 70) p.length_bytes = 12'($urandom_range(56, 2104));
				else if (r < 85) p.length_bytes = 12'($urandom_range(0, 55));
				else p.length_bytes = 12'($urandom_range(2105, 4095));
				offer_packet(p, 1'b0, '0, '0, 1'b0);
			end
		end

		// latest possible arrival
		p = '{flow_pool[0], 63'd0, Mask63[62:0], 12'd2104};
		offer_packet(p, 1'b0, '0, '0, 1'b0);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_records.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
